### hw/rtl/tdgl_pkg.sv
// ----------------------------------------------------------------------------
// tdgl_pkg: shared types and constants for the distance grid lookup
// Grid geometry, fixed-point widths, sequencer states and axis record.
// ----------------------------------------------------------------------------
package tdgl_pkg;

  localparam int unsigned GRID_SIDE   = 32;
  localparam int unsigned ADDR_W      = 15;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 24;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CW          = $clog2(GRID_SIDE);
  localparam int unsigned SW          = POS_W + CW + 1;
  localparam int unsigned CIW         = SW - FRAC_W;
  localparam int unsigned WW          = FRAC_W + 1;
  localparam int unsigned PW          = DATA_W + 2;
  localparam int unsigned VW          = 40;
  localparam int unsigned PRW         = VW + 1 + WW;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned QCW         = $clog2(NUM_CORNERS + 1);
  localparam int          ONE_Q16     = 1 << FRAC_W;
  localparam int          HALF_Q16    = ONE_Q16 / 2;
  localparam int          MILLI_Q16   = 66;
  localparam int          PEN_OFS     = (GRID_SIDE - 1) * ONE_Q16 - MILLI_Q16;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } tdgl_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_PEN,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } tdgl_state_t;

  typedef struct packed {
    logic signed [WW-1:0] w;
    logic [CW-1:0]        cidx;
    logic                 interior;
    logic signed [PW-1:0] pen;
  } tdgl_axis_t;

endpackage

### hw/rtl/tdgl_grid_store.sv
// ----------------------------------------------------------------------------
// tdgl_grid_store: single-port grid sample memory
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module tdgl_grid_store (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [tdgl_pkg::ADDR_W-1:0] addr,
  input  logic [tdgl_pkg::DATA_W-1:0] wdata,
  output logic [tdgl_pkg::DATA_W-1:0] rdata
);
  import tdgl_pkg::*;

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tdgl_axis_prep.sv
// ----------------------------------------------------------------------------
// tdgl_axis_prep: per-axis coordinate split
// Scale by grid side, truncate toward zero, form fraction, range and penalty.
// ----------------------------------------------------------------------------
module tdgl_axis_prep (
  input  logic signed [tdgl_pkg::POS_W-1:0] pos,
  output tdgl_pkg::tdgl_axis_t              info
);
  import tdgl_pkg::*;

  localparam logic signed [CIW-1:0] SIDE_C = CIW'(GRID_SIDE);

  logic signed [SW-1:0]  s;
  logic signed [SW-1:0]  s_adj;
  logic signed [SW-1:0]  diff;
  logic signed [CIW-1:0] c;
  logic                  below;
  logic                  above;

  always_comb begin
    s     = SW'(pos) * $signed(SW'(GRID_SIDE));
    s_adj = s[SW-1] ? (s + $signed(SW'(ONE_Q16 - 1))) : s;
    c     = CIW'(s_adj >>> FRAC_W);
    diff  = s - (SW'(c) <<< FRAC_W);
    below = c[CIW-1];
    above = !below && (c >= SIDE_C);

    info.w        = diff[WW-1:0];
    info.cidx     = c[CW-1:0];
    info.interior = !below && (c < SIDE_C - CIW'(1));
    if (below) begin
      info.pen = -PW'(s);
    end else if (above) begin
      info.pen = PW'(s) - $signed(PW'(PEN_OFS));
    end else begin
      info.pen = '0;
    end
  end

endmodule

### hw/rtl/tdgl_lerp_unit.sv
// ----------------------------------------------------------------------------
// tdgl_lerp_unit: shared linear blend unit
// Registers (b - a) * w, then adds the rounded, floored product to a.
// ----------------------------------------------------------------------------
module tdgl_lerp_unit (
  input  logic                              clk,
  input  logic                              mul_en,
  input  logic signed [tdgl_pkg::VW-1:0]    a,
  input  logic signed [tdgl_pkg::VW-1:0]    b,
  input  logic signed [tdgl_pkg::WW-1:0]    w,
  output logic signed [tdgl_pkg::VW-1:0]    res
);
  import tdgl_pkg::*;

  logic signed [VW:0]    d;
  logic signed [PRW-1:0] prod_nxt;
  logic signed [PRW-1:0] prod_r;
  logic signed [PRW-1:0] rnd;

  always_comb begin
    d        = (VW+1)'(b) - (VW+1)'(a);
    prod_nxt = PRW'(d) * PRW'(w);
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    rnd = (prod_r + $signed(PRW'(HALF_Q16))) >>> FRAC_W;
    res = a + VW'(rnd);
  end

endmodule

### hw/rtl/trilinear_distance_grid_lookup_core.sv
// ----------------------------------------------------------------------------
// trilinear_distance_grid_lookup_core: distance grid store and lookup
// Cubic grid of Q16.16 samples with trilinear query and out-of-grid penalty.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat is a write (kind 0, stores
//   in_cell_value at in_cell_index) or a query (kind 1, Q7.16 position).
//   Output channel (out_valid/out_ready): one beat per query, carrying the
//   saturated Q16.16 distance and the outside flag. Writes return nothing.
// Sequence:
//   A write is stored in the cycle it is accepted. An interior query runs a
//   split step, eight corner reads through the single memory port, seven
//   blends on one shared multiplier (a multiply and an add step each) and
//   an output step. An outside query runs the split step, accumulates the
//   penalty of the three axes and goes to the output step. One item is in
//   work at a time; in_ready is low while a query runs.
// Reset:
//   After reset a clearing pass writes the far value to all 32768 cells,
//   one per cycle; in_ready stays low until the pass is done.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted meanwhile, and a following query holds in its last step
//   until the output register frees.
// ----------------------------------------------------------------------------
module trilinear_distance_grid_lookup_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [tdgl_pkg::ADDR_W-1:0]       in_cell_index,
  input  logic [tdgl_pkg::DATA_W-1:0]       in_cell_value,
  input  logic signed [tdgl_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [tdgl_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [tdgl_pkg::POS_W-1:0] in_pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tdgl_pkg::DATA_W-1:0]       out_dist_out,
  output logic                              out_outside_grid
);
  import tdgl_pkg::*;

  tdgl_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          ax_cnt_r, ax_cnt_nxt;
  logic [QCW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic [QCW-1:0]      q_cnt_r, q_cnt_nxt;
  logic                pen_path_r, pen_path_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_dist_r, out_dist_nxt;
  logic                out_outside_r, out_outside_nxt;

  logic signed [POS_W-1:0] pos_r [3];
  logic signed [POS_W-1:0] pos_nxt [3];
  tdgl_axis_t              axis_info [3];
  tdgl_axis_t              axis_r [3];
  tdgl_axis_t              axis_nxt [3];
  logic signed [PW-1:0]    acc_r, acc_nxt;
  logic signed [VW-1:0]    q_r [NUM_CORNERS];
  logic signed [VW-1:0]    q_nxt [NUM_CORNERS];

  logic                    mem_en;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [DATA_W-1:0]       mem_wdata;
  logic [DATA_W-1:0]       mem_rdata;
  logic [ADDR_W-1:0]       corner_addr;
  logic [CW-1:0]           cx, cy, cz;
  logic [31:0]             addr_full;

  logic                    mul_en;
  logic signed [WW-1:0]    lerp_w;
  logic signed [VW-1:0]    lerp_res;
  logic                    in_ready_c;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    tdgl_axis_prep u_axis_prep (
      .pos  (pos_r[g]),
      .info (axis_info[g])
    );
  end

  tdgl_grid_store u_grid_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  tdgl_lerp_unit u_lerp_unit (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (q_r[0]),
    .b      (q_r[1]),
    .w      (lerp_w),
    .res    (lerp_res)
  );

  always_comb begin
    cx = axis_r[0].cidx + CW'(rd_cnt_r[0]);
    cy = axis_r[1].cidx + CW'(rd_cnt_r[1]);
    cz = axis_r[2].cidx + CW'(rd_cnt_r[2]);
    addr_full   = (32'(cz) * GRID_SIDE + 32'(cy)) * GRID_SIDE + 32'(cx);
    corner_addr = addr_full[ADDR_W-1:0];
  end

  always_comb begin
    if (q_cnt_r >= QCW'(5)) begin
      lerp_w = axis_r[0].w;
    end else if (q_cnt_r >= QCW'(3)) begin
      lerp_w = axis_r[1].w;
    end else begin
      lerp_w = axis_r[2].w;
    end
  end

  function automatic logic [DATA_W-1:0] sat_acc(input logic signed [PW-1:0] v);
    if (v[PW-1]) begin
      sat_acc = '0;
    end else if (|v[PW-2:DATA_W]) begin
      sat_acc = '1;
    end else begin
      sat_acc = v[DATA_W-1:0];
    end
  endfunction

  function automatic logic [DATA_W-1:0] sat_val(input logic signed [VW-1:0] v);
    if (v[VW-1]) begin
      sat_val = '0;
    end else if (|v[VW-2:DATA_W]) begin
      sat_val = '1;
    end else begin
      sat_val = v[DATA_W-1:0];
    end
  endfunction

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    ax_cnt_nxt      = ax_cnt_r;
    rd_cnt_nxt      = rd_cnt_r;
    q_cnt_nxt       = q_cnt_r;
    pen_path_nxt    = pen_path_r;
    acc_nxt         = acc_r;
    pos_nxt         = pos_r;
    axis_nxt        = axis_r;
    q_nxt           = q_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_dist_nxt    = out_dist_r;
    out_outside_nxt = out_outside_r;
    in_ready_c      = 1'b0;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = corner_addr;
    mem_wdata       = in_cell_value;
    mul_en          = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_c = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_QUERY) begin
            pos_nxt[0] = in_pos_x;
            pos_nxt[1] = in_pos_y;
            pos_nxt[2] = in_pos_z;
            state_nxt  = ST_PREP;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = in_cell_index;
          end
        end
      end
      ST_PREP: begin
        axis_nxt   = axis_info;
        ax_cnt_nxt = '0;
        acc_nxt    = '0;
        rd_cnt_nxt = '0;
        if (axis_info[0].interior && axis_info[1].interior && axis_info[2].interior) begin
          pen_path_nxt = 1'b0;
          state_nxt    = ST_READ;
        end else begin
          pen_path_nxt = 1'b1;
          state_nxt    = ST_PEN;
        end
      end
      ST_PEN: begin
        acc_nxt    = acc_r + axis_r[ax_cnt_r].pen;
        ax_cnt_nxt = ax_cnt_r + 2'd1;
        if (ax_cnt_r == 2'd2) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        if (rd_cnt_r != QCW'(NUM_CORNERS)) begin
          mem_en     = 1'b1;
          rd_cnt_nxt = rd_cnt_r + QCW'(1);
        end
        if (rd_cnt_r != '0) begin
          for (int i = 0; i < NUM_CORNERS - 1; i++) begin
            q_nxt[i] = q_r[i+1];
          end
          q_nxt[NUM_CORNERS-1] = $signed(VW'(mem_rdata));
        end
        if (rd_cnt_r == QCW'(NUM_CORNERS)) begin
          q_cnt_nxt = QCW'(NUM_CORNERS);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int i = 0; i < NUM_CORNERS - 2; i++) begin
          if (QCW'(i) + QCW'(2) < q_cnt_r) begin
            q_nxt[i] = q_r[i+2];
          end
        end
        for (int i = 0; i < NUM_CORNERS; i++) begin
          if (QCW'(i) + QCW'(2) == q_cnt_r) begin
            q_nxt[i] = lerp_res;
          end
        end
        q_cnt_nxt = q_cnt_r - QCW'(1);
        if (q_cnt_r == QCW'(2)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_dist_nxt    = pen_path_r ? sat_acc(acc_r) : sat_val(q_r[0]);
          out_outside_nxt = pen_path_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_cnt_r      <= ax_cnt_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    q_cnt_r       <= q_cnt_nxt;
    pen_path_r    <= pen_path_nxt;
    acc_r         <= acc_nxt;
    pos_r         <= pos_nxt;
    axis_r        <= axis_nxt;
    q_r           <= q_nxt;
    out_dist_r    <= out_dist_nxt;
    out_outside_r <= out_outside_nxt;
  end

  assign in_ready         = in_ready_c;
  assign out_valid        = out_valid_r;
  assign out_dist_out     = out_dist_r;
  assign out_outside_grid = out_outside_r;

`ifndef SYNTHESIS
  a_query_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == KIND_QUERY) |=> !in_ready)
    else $error("input taken while a query is in work");

  a_read_only_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |->
      (axis_r[0].interior && axis_r[1].interior && axis_r[2].interior))
    else $error("corner fetch for a point outside the interior");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_ADD) |->
      (q_cnt_r >= QCW'(2) && q_cnt_r <= QCW'(NUM_CORNERS)))
    else $error("blend queue depth out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result beat raised outside the done step");
`endif

endmodule
